>>> hdl/sensor_packet_frame_checker_core_defines.svh
// ----------------------------------------------------------------------------
// Sensor packet frame checker - assertion macros
// Concurrent check helpers for the frame checker; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_FRAME_CHECKER_CORE_DEFINES_SVH
`define SENSOR_PACKET_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds whenever ante holds, in the same cycle
`define SPFC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame checker assertion failed");
// Check that cons holds in the cycle after ante
`define SPFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame checker assertion failed");
`else
`define SPFC_ASSERT_NOW(lbl, ante, cons)
`define SPFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/spfc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor packet frame checker - package
// Status codes, register indexes, field widths and the result beat type.
// ----------------------------------------------------------------------------
package spfc_pkg;

	// Largest frame length field accepted regardless of the length registers
	localparam int unsigned MAX_FRAME_LENGTH = 512;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 40;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_HEADER_WORD = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACK_FLAG    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DATA_FLAG   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_END_FLAG    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_EXPECT_DATA = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_LENGTH  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH  = 3'd6;

	// Frame status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_HDR   = 3'd1;
	localparam logic [2:0] ST_BAD_FLAG  = 3'd2;
	localparam logic [2:0] ST_BAD_LEN   = 3'd3;
	localparam logic [2:0] ST_BAD_CKSUM = 3'd4;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// One result beat
	typedef struct packed {
		logic       kind;
		logic [7:0] payload_value;
		logic [8:0] payload_index;
		logic [2:0] frame_status;
		logic [7:0] packet_flag;
		logic [8:0] data_count;
		logic       last;
	} spfc_result_t;

endpackage

>>> hdl/sensor_packet_frame_checker_core.sv
// Deframes fingerprint-module serial packets one byte per beat: one byte is
// accepted every clock cycle while s_tready is high, and the byte's result
// (a payload byte or the closing frame status) is registered into the output
// register, or into the skid register under back-pressure. The whole per-byte
// step is one pass of compare and 16-bit add logic between the frame state
// registers and the output register; a two-entry output stage (output
// register plus skid register) takes one more result under output
// back-pressure, and s_tready drops only once that skid register is occupied.
// ----------------------------------------------------------------------------
// Sensor packet frame checker - top level
// Header, flag, length and checksum checks with payload byte streaming.
// ----------------------------------------------------------------------------
`include "sensor_packet_frame_checker_core_defines.svh"

module sensor_packet_frame_checker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [spfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [spfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// received bytes
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [spfc_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] rx_data
	input  logic                              s_tuser,  // restart
	// results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] payload_value, [16:8] payload_index, [19:17] frame_status,
	// [27:20] packet_flag, [36:28] data_count, [39:37] zero
	output logic [spfc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,  // kind
	output logic                              m_tlast   // last
);
	import spfc_pkg::*;

	// Frame phases
	localparam logic [3:0] PH_HDR_HI = 4'd0;
	localparam logic [3:0] PH_HDR_LO = 4'd1;
	localparam logic [3:0] PH_ADDR   = 4'd2;
	localparam logic [3:0] PH_FLAG   = 4'd3;
	localparam logic [3:0] PH_LEN_HI = 4'd4;
	localparam logic [3:0] PH_LEN_LO = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_CK_HI  = 4'd7;
	localparam logic [3:0] PH_CK_LO  = 4'd8;

	localparam logic [15:0] MAX_LEN_W = 16'(MAX_FRAME_LENGTH);
	localparam logic [9:0]  ADDR_BYTES = 10'd4;

	// Configuration registers
	logic [15:0] header_word_q;
	logic [7:0]  ack_flag_q;
	logic [7:0]  data_flag_q;
	logic [7:0]  end_flag_q;
	logic        expect_data_q;
	logic [9:0]  min_length_q;
	logic [9:0]  max_length_q;

	// Frame state
	logic [3:0]  phase_q, phase_d;
	logic [9:0]  cnt_q, cnt_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  flag_q, flag_d;
	logic [9:0]  len_q, len_d;
	logic [7:0]  hold_q, hold_d;

	// Output stage
	spfc_result_t main_q, skid_q, res;
	logic         skid_valid_q;
	logic         res_valid;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] word;
	logic [9:0]  cnt_inc;
	logic [9:0]  len_m2;
	logic        flag_ok;
	logic        len_bad;
	logic        take_main;

	assign accept  = s_tvalid && s_tready;
	assign b       = s_tdata[7:0];
	assign word    = {hold_q, b};
	assign cnt_inc = cnt_q + 10'd1;
	assign len_m2  = len_q - 10'd2;
	assign flag_ok = expect_data_q ? ((b == data_flag_q) || (b == end_flag_q))
	                               : (b == ack_flag_q);
	assign len_bad = (word < 16'd2) || (word < {6'd0, min_length_q}) ||
	                 (word > {6'd0, max_length_q}) || (word > MAX_LEN_W);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_word_q <= 16'hEF01;
			ack_flag_q    <= 8'd7;
			data_flag_q   <= 8'd2;
			end_flag_q    <= 8'd8;
			expect_data_q <= 1'b0;
			min_length_q  <= 10'd3;
			max_length_q  <= 10'd256;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HEADER_WORD: header_word_q <= cfg_wdata;
				REG_ACK_FLAG:    ack_flag_q    <= cfg_wdata[7:0];
				REG_DATA_FLAG:   data_flag_q   <= cfg_wdata[7:0];
				REG_END_FLAG:    end_flag_q    <= cfg_wdata[7:0];
				REG_EXPECT_DATA: expect_data_q <= cfg_wdata[0];
				REG_MIN_LENGTH:  min_length_q  <= cfg_wdata[9:0];
				REG_MAX_LENGTH:  max_length_q  <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// Step the frame state for one byte and form its result
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		flag_d    = flag_q;
		len_d     = len_q;
		hold_d    = hold_q;
		res_valid = 1'b0;
		res       = '0;
		res.kind  = KIND_STATUS;
		res.last  = 1'b1;

		if (s_tuser) begin
			// drop the partial frame without a result
			phase_d = PH_HDR_HI;
			cnt_d   = '0;
			sum_d   = '0;
		end else begin
			unique case (phase_q)
				PH_HDR_HI: begin
					hold_d  = b;
					phase_d = PH_HDR_LO;
				end
				PH_HDR_LO: begin
					cnt_d = '0;
					if (word != header_word_q) begin
						res_valid        = 1'b1;
						res.frame_status = ST_BAD_HDR;
						phase_d          = PH_HDR_HI;
						sum_d            = '0;
					end else begin
						phase_d = PH_ADDR;
					end
				end
				PH_ADDR: begin
					// skip the four address bytes
					if (cnt_inc >= ADDR_BYTES) begin
						cnt_d   = '0;
						phase_d = PH_FLAG;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_FLAG: begin
					flag_d = b;
					if (!flag_ok) begin
						res_valid        = 1'b1;
						res.frame_status = ST_BAD_FLAG;
						res.packet_flag  = b;
						phase_d          = PH_HDR_HI;
						cnt_d            = '0;
						sum_d            = '0;
					end else begin
						sum_d   = {8'd0, b};
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					hold_d  = b;
					sum_d   = sum_q + {8'd0, b};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d = word[9:0];
					cnt_d = '0;
					if (len_bad) begin
						res_valid        = 1'b1;
						res.frame_status = ST_BAD_LEN;
						res.packet_flag  = flag_q;
						phase_d          = PH_HDR_HI;
						sum_d            = '0;
					end else begin
						sum_d   = sum_q + {8'd0, b};
						phase_d = (word == 16'd2) ? PH_CK_HI : PH_DATA;
					end
				end
				PH_DATA: begin
					// pass the payload byte through
					res_valid         = 1'b1;
					res.kind          = KIND_PAYLOAD;
					res.last          = 1'b0;
					res.payload_value = b;
					res.payload_index = cnt_q[8:0];
					res.packet_flag   = flag_q;
					sum_d             = sum_q + {8'd0, b};
					cnt_d             = cnt_inc;
					if (cnt_inc >= len_m2)
						phase_d = PH_CK_HI;
				end
				PH_CK_HI: begin
					hold_d  = b;
					phase_d = PH_CK_LO;
				end
				PH_CK_LO: begin
					res_valid        = 1'b1;
					res.frame_status = (word == sum_q) ? ST_OK : ST_BAD_CKSUM;
					res.packet_flag  = flag_q;
					res.data_count   = len_m2[8:0];
					phase_d          = PH_HDR_HI;
					cnt_d            = '0;
					sum_d            = '0;
				end
				default: begin
					// unused phase codes resynchronize on this byte
					hold_d  = b;
					phase_d = PH_HDR_LO;
					cnt_d   = '0;
					sum_d   = '0;
				end
			endcase
		end
	end

	// Advance the frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_HI;
			cnt_q   <= '0;
			sum_q   <= '0;
			flag_q  <= '0;
			len_q   <= '0;
			hold_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			flag_q  <= flag_d;
			len_q   <= len_d;
			hold_q  <= hold_d;
		end
	end

	// New result goes to the output register when it is free or draining
	assign take_main = !m_tvalid || (m_tready && !skid_valid_q);
	assign s_tready  = !skid_valid_q;

	// Track output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			// land the new result in the output register or park it in the skid
			if (take_main)
				m_tvalid <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			m_tvalid     <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// Hold result payloads
	always_ff @(posedge clk) begin
		if (m_tvalid && m_tready && skid_valid_q)
			main_q <= skid_q;
		if (accept && res_valid) begin
			if (take_main)
				main_q <= res;
			else
				skid_q <= res;
		end
	end

	assign m_tdata = {3'd0, main_q.data_count, main_q.packet_flag, main_q.frame_status,
	                  main_q.payload_index, main_q.payload_value};
	assign m_tuser = main_q.kind;
	assign m_tlast = main_q.last;

	// Checks
	`SPFC_ASSERT_NOW(a_skid_behind_main, skid_valid_q, m_tvalid)
	`SPFC_ASSERT_NEXT(a_restart_hunts, accept && s_tuser, phase_q == PH_HDR_HI)
	`SPFC_ASSERT_NOW(a_data_len_sane, phase_q == PH_DATA, (len_q > 10'd2) && (cnt_q < len_m2))
	`SPFC_ASSERT_NOW(a_kind_matches_last, m_tvalid, m_tuser == m_tlast)

endmodule

>>> tb/sensor_packet_frame_checker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor packet frame checker - block test
// Feeds byte streams of framed packets (good frames, bad header, flag, length
// and checksum, truncated frames, restarts and noise) under several register
// sets. Predicts every payload and status beat in the test and compares the
// results field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module sensor_packet_frame_checker_core_test;
	import spfc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [7:0] value;
		logic       restart;
	} rx_item_t;

	typedef enum logic [3:0] {
		SEEK_HI, SEEK_LO, SKIP_ADDR, TAKE_FLAG, TAKE_LEN_HI, TAKE_LEN_LO,
		TAKE_BODY, TAKE_SUM_HI, TAKE_SUM_LO
	} deframe_state_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;  // [7:0] rx_data
	logic s_tuser = 1'b0;                // restart
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [7:0] payload_value, [16:8] payload_index, [19:17] frame_status,
	// [27:20] packet_flag, [36:28] data_count, [39:37] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;                       // kind
	logic m_tlast;                       // last

	sensor_packet_frame_checker_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Mirror of the register file
	logic [15:0] cfg_header;
	logic [7:0]  cfg_ack_flag, cfg_data_flag, cfg_end_flag;
	logic        cfg_expect_data;
	logic [9:0]  cfg_min_len, cfg_max_len;

	// Deframer prediction state
	deframe_state_e df_state;
	int unsigned    df_count;
	logic [15:0]    df_sum;
	logic [7:0]     df_flag;
	logic [15:0]    df_len;
	logic [7:0]     df_held;

	rx_item_t     bytes_to_send[$];
	spfc_result_t frame_results_due[$];

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned queued_total = 0;
	int unsigned bytes_in = 0;
	int unsigned payload_beats = 0;
	int unsigned good_frames = 0;
	int unsigned rejected_frames = 0;
	int unsigned hold_left = 0;
	bit pressure_done = 1'b0;
	bit no_gaps = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic void restart_hunt();
		df_state = SEEK_HI;
		df_count = 0;
		df_sum = '0;
	endfunction

	function automatic spfc_result_t status_beat(logic [2:0] code, logic [7:0] flag,
			logic [15:0] count);
		spfc_result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.frame_status = code;
		r.packet_flag = flag;
		r.data_count = count[8:0];
		r.last = 1'b1;
		return r;
	endfunction

	// Advance the deframer by one byte; got is set when a beat comes out
	task automatic deframe_byte(input logic [7:0] b, input logic rs, output bit got,
			output spfc_result_t r);
		logic [15:0] word;
		bit ok;
		got = 1'b0;
		r = '0;
		if (rs) begin
			restart_hunt();
			return;
		end
		case (df_state)
			SEEK_HI: begin
				df_held = b;
				df_state = SEEK_LO;
			end
			SEEK_LO: begin
				word = {df_held, b};
				if (word != cfg_header) begin
					r = status_beat(ST_BAD_HDR, 8'h00, 16'd0);
					got = 1'b1;
				end else begin
					df_state = SKIP_ADDR;
					df_count = 0;
				end
			end
			SKIP_ADDR: begin
				df_count++;
				if (df_count >= 4) begin
					df_count = 0;
					df_state = TAKE_FLAG;
				end
			end
			TAKE_FLAG: begin
				df_flag = b;
				ok = cfg_expect_data ? (b == cfg_data_flag || b == cfg_end_flag)
					: (b == cfg_ack_flag);
				if (!ok) begin
					r = status_beat(ST_BAD_FLAG, b, 16'd0);
					got = 1'b1;
				end else begin
					df_sum = 16'(b);
					df_state = TAKE_LEN_HI;
				end
			end
			TAKE_LEN_HI: begin
				df_held = b;
				df_sum = df_sum + 16'(b);
				df_state = TAKE_LEN_LO;
			end
			TAKE_LEN_LO: begin
				df_len = {df_held, b};
				df_sum = df_sum + 16'(b);
				if (df_len < 2 || df_len < cfg_min_len || df_len > cfg_max_len ||
						df_len > MAX_FRAME_LENGTH) begin
					r = status_beat(ST_BAD_LEN, df_flag, 16'd0);
					got = 1'b1;
				end else begin
					df_count = 0;
					df_state = (df_len == 2) ? TAKE_SUM_HI : TAKE_BODY;
				end
			end
			TAKE_BODY: begin
				r.kind = KIND_PAYLOAD;
				r.payload_value = b;
				r.payload_index = df_count[8:0];
				r.packet_flag = df_flag;
				got = 1'b1;
				df_sum = df_sum + 16'(b);
				df_count++;
				if (df_count >= df_len - 2) df_state = TAKE_SUM_HI;
			end
			TAKE_SUM_HI: begin
				df_held = b;
				df_state = TAKE_SUM_LO;
			end
			TAKE_SUM_LO: begin
				word = {df_held, b};
				r = status_beat((word == df_sum) ? ST_OK : ST_BAD_CKSUM, df_flag,
					df_len - 16'd2);
				got = 1'b1;
			end
			default: restart_hunt();
		endcase
		// every status sends the deframer back to header hunting
		if (got && r.kind == KIND_STATUS) restart_hunt();
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void queue_byte(logic [7:0] v, logic rs = 1'b0);
		rx_item_t it;
		it.value = v;
		it.restart = rs;
		bytes_to_send.push_back(it);
		queued_total++;
	endfunction

	// Write one register at a clock edge and keep the mirror in step
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_HEADER_WORD: cfg_header = value;
			REG_ACK_FLAG:    cfg_ack_flag = value[7:0];
			REG_DATA_FLAG:   cfg_data_flag = value[7:0];
			REG_END_FLAG:    cfg_end_flag = value[7:0];
			REG_EXPECT_DATA: cfg_expect_data = value[0];
			REG_MIN_LENGTH:  cfg_min_len = value[9:0];
			REG_MAX_LENGTH:  cfg_max_len = value[9:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Build a frame; stop at the byte the block rejects. A cut of zero or more
	// truncates the frame after that many bytes and follows it with a restart.
	task automatic queue_frame(logic [15:0] word, logic [7:0] flag, logic [15:0] len,
			bit spoil, int cut);
		logic [7:0] frame[$];
		logic [15:0] sum;
		logic [7:0] v;
		bit flag_ok;
		bit len_ok;
		frame.push_back(word[15:8]);
		frame.push_back(word[7:0]);
		if (word == cfg_header) begin
			repeat (4) frame.push_back(8'($urandom_range(0, 255)));
			frame.push_back(flag);
			flag_ok = cfg_expect_data ? (flag == cfg_data_flag || flag == cfg_end_flag)
				: (flag == cfg_ack_flag);
			if (flag_ok) begin
				frame.push_back(len[15:8]);
				frame.push_back(len[7:0]);
				len_ok = len >= 2 && len >= cfg_min_len && len <= cfg_max_len &&
					len <= MAX_FRAME_LENGTH;
				if (len_ok) begin
					sum = 16'(flag) + 16'(len[15:8]) + 16'(len[7:0]);
					for (int i = 0; i < int'(len) - 2; i++) begin
						v = 8'($urandom_range(0, 255));
						sum = sum + 16'(v);
						frame.push_back(v);
					end
					if (spoil) sum = sum ^ (16'd1 << $urandom_range(0, 15));
					frame.push_back(sum[15:8]);
					frame.push_back(sum[7:0]);
				end
			end
		end
		for (int i = 0; i < frame.size() && (cut < 0 || i < cut); i++)
			queue_byte(frame[i]);
		if (cut >= 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Mostly well-formed frames with random content; the rest is broken
	task automatic queue_random_frame();
		int r, lo, hi, cut;
		logic [15:0] word, len;
		logic [7:0] flag;
		bit spoil;
		r = $urandom_range(0, 99);
		word = cfg_header;
		if (r < 5) word = cfg_header ^ 16'($urandom_range(1, 65535));
		if (cfg_expect_data) flag = $urandom_range(0, 1) ? cfg_data_flag : cfg_end_flag;
		else flag = cfg_ack_flag;
		if (r >= 5 && r < 10) flag = 8'($urandom_range(0, 255));
		lo = (cfg_min_len < 2) ? 2 : int'(cfg_min_len);
		hi = (cfg_max_len > MAX_FRAME_LENGTH) ? int'(MAX_FRAME_LENGTH) : int'(cfg_max_len);
		// keep most frames short
		if (hi > lo + 20) hi = lo + 20;
		if ((r >= 10 && r < 16) || lo > hi) begin
			case ($urandom_range(0, 4))
				0: len = 16'd0;
				1: len = 16'd1;
				2: len = 16'(lo - 1);
				3: len = 16'(cfg_max_len) + 16'd1;
				default: len = 16'($urandom_range(0, 65535));
			endcase
		end else begin
			len = 16'($urandom_range(lo, hi));
		end
		spoil = (r >= 16 && r < 24);
		cut = (r >= 24 && r < 30) ? $urandom_range(0, 30) : -1;
		// line noise ahead of the frame, cleared by a restart
		if (r >= 30 && r < 35) begin
			repeat ($urandom_range(1, 5)) queue_byte(8'($urandom_range(0, 255)));
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		queue_frame(word, flag, len, spoil, cut);
	endtask

	task automatic queue_random_frames(int unsigned count);
		int unsigned start;
		start = queued_total;
		while (queued_total - start < count) queue_random_frame();
	endtask

	// Hold until every byte is taken and every result is back, then settle
	task automatic wait_idle();
		do @(negedge clk);
		while (bytes_to_send.size() != 0 || s_tvalid || frame_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued bytes, predict each accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		bit got;
		spfc_result_t beat;
		rx_item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata, s_tuser, got, beat);
				if (got) frame_results_due.push_back(beat);
				bytes_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (bytes_to_send.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
					nxt = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.value;
					s_tuser <= nxt.restart;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result beat with the oldest prediction
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : watch
		spfc_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_results_due.size() == 0) begin
					$error("unexpected result beat: tuser=%b tdata=%h", m_tuser, m_tdata);
					errors++;
				end else begin
					want = frame_results_due.pop_front();
					check_field("kind", 16'(want.kind), 16'(m_tuser));
					check_field("payload_value", 16'(want.payload_value), 16'(m_tdata[7:0]));
					check_field("payload_index", 16'(want.payload_index),
						16'(m_tdata[16:8]));
					check_field("frame_status", 16'(want.frame_status),
						16'(m_tdata[19:17]));
					check_field("packet_flag", 16'(want.packet_flag), 16'(m_tdata[27:20]));
					check_field("data_count", 16'(want.data_count), 16'(m_tdata[36:28]));
					check_field("last", 16'(want.last), 16'(m_tlast));
				end
				if (m_tuser == KIND_PAYLOAD) payload_beats++;
				else if (m_tdata[19:17] == ST_OK) good_frames++;
				else rejected_frames++;
			end
			// hold off once for a long stretch while plenty of bytes wait
			if (!pressure_done && bytes_to_send.size() > 100 && bytes_in > 100) begin
				hold_left = 150;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || $urandom_range(0, 99) >= 36;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_header = 16'hEF01;
		cfg_ack_flag = 8'd7;
		cfg_data_flag = 8'd2;
		cfg_end_flag = 8'd8;
		cfg_expect_data = 1'b0;
		cfg_min_len = 10'd3;
		cfg_max_len = 10'd256;
		df_flag = '0;
		df_len = '0;
		df_held = '0;
		restart_hunt();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: bad header, restart after a good header, good acknowledge
		// with one confirm byte, bad flag
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'hEF);
		queue_byte(8'h01);
		queue_byte(8'hA5, 1'b1);
		queue_frame(16'hEF01, 8'd7, 16'd3, 1'b0, -1);
		queue_frame(16'hEF01, 8'hFF, 16'd3, 1'b0, -1);
		wait_idle();

		// Data mode, widest length window: empty payload and largest frame
		write_reg(REG_HEADER_WORD, 16'($urandom_range(0, 65535)));
		write_reg(REG_ACK_FLAG, 16'($urandom_range(0, 255)));
		write_reg(REG_DATA_FLAG, 16'($urandom_range(0, 255)));
		write_reg(REG_END_FLAG, 16'($urandom_range(0, 255)));
		write_reg(REG_EXPECT_DATA, 16'd1);
		write_reg(REG_MIN_LENGTH, 16'd2);
		write_reg(REG_MAX_LENGTH, 16'd512);
		@(negedge clk);
		queue_frame(cfg_header, cfg_data_flag, 16'd2, 1'b0, -1);
		queue_frame(cfg_header, cfg_end_flag, 16'd512, 1'b0, -1);
		queue_frame(cfg_header, cfg_end_flag, 16'd513, 1'b0, -1);
		queue_random_frames(40);
		wait_idle();

		// Acknowledge mode, only empty payloads fit; no gaps on either side
		write_reg(REG_HEADER_WORD, 16'h0000);
		write_reg(REG_ACK_FLAG, 16'h00FF);
		write_reg(REG_EXPECT_DATA, 16'd0);
		write_reg(REG_MAX_LENGTH, 16'd2);
		@(negedge clk);
		no_gaps = 1'b1;
		queue_random_frames(50);
		wait_idle();
		no_gaps = 1'b0;

		// Data mode with flag extremes and a narrow length window
		write_reg(REG_HEADER_WORD, 16'hFFFF);
		write_reg(REG_DATA_FLAG, 16'h0000);
		write_reg(REG_END_FLAG, 16'h00FF);
		write_reg(REG_EXPECT_DATA, 16'd1);
		write_reg(REG_MIN_LENGTH, 16'd20);
		write_reg(REG_MAX_LENGTH, 16'd40);
		@(negedge clk);
		queue_random_frames(30);
		wait_idle();

		// Back to the reset values
		write_reg(REG_HEADER_WORD, 16'hEF01);
		write_reg(REG_ACK_FLAG, 16'd7);
		write_reg(REG_DATA_FLAG, 16'd2);
		write_reg(REG_END_FLAG, 16'd8);
		write_reg(REG_EXPECT_DATA, 16'd0);
		write_reg(REG_MIN_LENGTH, 16'd3);
		write_reg(REG_MAX_LENGTH, 16'd256);
		@(negedge clk);
		queue_random_frames(20);
		wait_idle();

		$display("Sent %0d bytes over five register sets; got %0d payload bytes,",
			bytes_in, payload_beats);
		$display("%0d frames passed and %0d rejected or failed checksum.",
			good_frames, rejected_frames);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
